// ===== rtl/core/pas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic alarm scheduler package
// Shared codes, calendar helpers and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package pas_pkg;

    // Skip counter: the reported count is SKIP_W bits and saturates at SKIP_MAX.
    localparam int SKIP_BITS = 16;
    localparam int SKIP_W    = 16;
    localparam logic [SKIP_W-1:0] SKIP_MAX = (SKIP_BITS >= SKIP_W) ? {SKIP_W{1'b1}} :
                                             SKIP_W'((64'd1 << SKIP_BITS) - 64'd1);

    // Calendar limits.
    localparam logic [6:0] SECS_PER_MIN    = 7'd60;
    localparam logic [6:0] MINS_PER_HOUR   = 7'd60;
    localparam logic [5:0] HOURS_PER_DAY   = 6'd24;
    localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [5:0] SEC_LAST        = 6'd59;
    localparam logic [5:0] MIN_LAST        = 6'd59;
    localparam logic [4:0] HOUR_LAST       = 5'd23;
    localparam logic [3:0] MONTH_FEB       = 4'd2;

    // Year numbering starts at the epoch year; within the 8-bit span the only
    // century years are 2000, 2100 and 2200, and only 2000 is a multiple of 400.
    localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
    localparam logic [11:0] CENTURY_2100 = 12'd2100;
    localparam logic [11:0] CENTURY_2200 = 12'd2200;

    // Request opcodes.
    localparam logic OP_START    = 1'b0;
    localparam logic OP_SCHEDULE = 1'b1;

    // Period status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_ZERO  = 2'd2;

    // Alarm match modes.
    localparam logic [1:0] MODE_EVERY_SEC  = 2'd0;
    localparam logic [1:0] MODE_MATCH_SEC  = 2'd1;
    localparam logic [1:0] MODE_MATCH_MIN  = 2'd2;
    localparam logic [1:0] MODE_MATCH_HOUR = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PERIOD_SECONDS = 2'd0;
    localparam logic [1:0] CFG_PERIOD_MINUTES = 2'd1;
    localparam logic [1:0] CFG_PERIOD_HOURS   = 2'd2;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic normalize;
        logic eval;
        logic step;
        logic load_out;
    } pas_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic op;
        logic period_ok;
        logic alarm_lt_now;
        logic adv;
    } pas_stat_t;

    function automatic logic is_leap(input logic [7:0] year);
        logic [11:0] full;
        full = EPOCH_YEAR + {4'd0, year};
        return (full[1:0] == 2'b00) && (full != CENTURY_2100) && (full != CENTURY_2200);
    endfunction

    function automatic logic [4:0] month_len(input logic [7:0] year, input logic [3:0] month);
        logic [4:0] base;
        case (month) inside
            MONTH_FEB:                   base = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:     base = 5'd30;
            default:                     base = 5'd31;
        endcase
        return base + {4'd0, (month == MONTH_FEB) && is_leap(year)};
    endfunction

endpackage

// ===== rtl/core/pas_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic alarm scheduler controller
// Sequences capture, normalization, evaluation, catch-up and result hand-off.
// ----------------------------------------------------------------------------
module pas_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  pas_pkg::pas_stat_t stat,
    output pas_pkg::pas_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_NORM = 5'b00010,
        ST_EVAL = 5'b00100,
        ST_STEP = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_NORM;
                end
            end
            ST_NORM: begin
                cmd.normalize = 1'b1;
                state_next    = ST_EVAL;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (stat.op == pas_pkg::OP_SCHEDULE && stat.period_ok && stat.alarm_lt_now) begin
                    state_next = ST_STEP;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_STEP: begin
                // One period per cycle until the alarm catches up or wraps.
                if (stat.adv) begin
                    cmd.step = 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_load_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result loaded while the output register is still full");

    a_step_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP) |-> ($past(state_reg) == ST_EVAL || $past(state_reg) == ST_STEP))
        else $error("catch-up entered without an evaluation");

endmodule

// ===== rtl/core/pas_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic alarm scheduler datapath
// Period registers, alarm and skip state, current-time normalization, the
// one-period calendar adder and the result register.
// ----------------------------------------------------------------------------
module pas_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [5:0]                 cfg_data,
    input  logic                       s_op,
    input  logic [7:0]                 s_now_year,
    input  logic [3:0]                 s_now_month,
    input  logic [4:0]                 s_now_day,
    input  logic [4:0]                 s_now_hour,
    input  logic [5:0]                 s_now_minute,
    input  logic [5:0]                 s_now_second,
    input  logic                       s_timer_fired,
    input  pas_pkg::pas_cmd_t          cmd,
    output pas_pkg::pas_stat_t         stat,
    output logic [1:0]                 m_status,
    output logic [1:0]                 m_match_mode,
    output logic [7:0]                 m_alarm_year,
    output logic [3:0]                 m_alarm_month,
    output logic [4:0]                 m_alarm_day,
    output logic [4:0]                 m_alarm_hour,
    output logic [5:0]                 m_alarm_minute,
    output logic [5:0]                 m_alarm_second,
    output logic [pas_pkg::SKIP_W-1:0] m_skipped_cycles
);

    // Period configuration.
    logic [5:0] per_sec_reg, per_min_reg;
    logic [4:0] per_hour_reg;

    // Captured request.
    logic       op_reg;
    logic [7:0] raw_year_reg;
    logic [3:0] raw_month_reg;
    logic [4:0] raw_day_reg, raw_hour_reg;
    logic [5:0] raw_minute_reg, raw_second_reg;

    // Normalized current time; year 256 stands for the end of the calendar.
    logic [8:0] now_year_reg, norm_year_next;
    logic [3:0] now_month_reg, norm_month_next;
    logic [4:0] now_day_reg, norm_day_next, now_hour_reg, norm_hour_next;
    logic [5:0] now_minute_reg, norm_minute_next, now_second_reg, norm_second_next;
    logic [4:0] raw_ml;
    logic       norm_inc_day, norm_new_month;

    // Alarm and skip state.
    logic [7:0] alarm_year_reg;
    logic [3:0] alarm_month_reg;
    logic [4:0] alarm_day_reg, alarm_hour_reg;
    logic [5:0] alarm_minute_reg, alarm_second_reg;
    logic [pas_pkg::SKIP_W-1:0] skip_reg;
    logic       wake_pending_reg, first_reg, wrap_reg;

    // One-period advance.
    logic [6:0] sum_sec, sum_min;
    logic [5:0] sum_hour;
    logic       carry_sec, carry_min, carry_hour;
    logic [4:0] alarm_ml;
    logic [7:0] adv_year_next;
    logic [3:0] adv_month_next;
    logic [4:0] adv_day_next, adv_hour_next;
    logic [5:0] adv_minute_next, adv_second_next;
    logic       adv_wrap_next;

    logic [1:0] period_status, period_mode;
    logic       alarm_lt_now;

    // ------------------------------------------------------------------
    // Period checks
    // ------------------------------------------------------------------
    always_comb begin
        if (per_hour_reg > pas_pkg::HOUR_LAST || per_min_reg > pas_pkg::MIN_LAST ||
            per_sec_reg > pas_pkg::SEC_LAST) begin
            period_status = pas_pkg::STATUS_RANGE;
        end else if (per_hour_reg == 5'd0 && per_min_reg == 6'd0 && per_sec_reg == 6'd0) begin
            period_status = pas_pkg::STATUS_ZERO;
        end else begin
            period_status = pas_pkg::STATUS_OK;
        end

        if (period_status != pas_pkg::STATUS_OK) begin
            period_mode = pas_pkg::MODE_EVERY_SEC;
        end else if (per_hour_reg != 5'd0) begin
            period_mode = pas_pkg::MODE_MATCH_HOUR;
        end else if (per_min_reg != 6'd0) begin
            period_mode = pas_pkg::MODE_MATCH_MIN;
        end else if (per_sec_reg == 6'd1) begin
            period_mode = pas_pkg::MODE_EVERY_SEC;
        end else begin
            period_mode = pas_pkg::MODE_MATCH_SEC;
        end
    end

    // ------------------------------------------------------------------
    // Current time normalization: an out-of-range field rounds up to the
    // start of the next larger unit, a zero month or day to the start of
    // the enclosing unit.
    // ------------------------------------------------------------------
    assign raw_ml = pas_pkg::month_len(raw_year_reg, raw_month_reg);

    always_comb begin
        norm_year_next   = {1'b0, raw_year_reg};
        norm_month_next  = raw_month_reg;
        norm_day_next    = raw_day_reg;
        norm_hour_next   = raw_hour_reg;
        norm_minute_next = raw_minute_reg;
        norm_second_next = raw_second_reg;
        norm_inc_day     = 1'b0;
        norm_new_month   = 1'b0;
        if (raw_month_reg > pas_pkg::MONTHS_PER_YEAR) begin
            norm_year_next   = {1'b0, raw_year_reg} + 9'd1;
            norm_month_next  = 4'd1;
            norm_day_next    = 5'd1;
            norm_hour_next   = 5'd0;
            norm_minute_next = 6'd0;
            norm_second_next = 6'd0;
        end else if (raw_month_reg == 4'd0) begin
            norm_month_next  = 4'd1;
            norm_day_next    = 5'd1;
            norm_hour_next   = 5'd0;
            norm_minute_next = 6'd0;
            norm_second_next = 6'd0;
        end else if (raw_day_reg == 5'd0) begin
            norm_day_next    = 5'd1;
            norm_hour_next   = 5'd0;
            norm_minute_next = 6'd0;
            norm_second_next = 6'd0;
        end else begin
            if (raw_day_reg > raw_ml) begin
                norm_new_month = 1'b1;
            end else if (raw_hour_reg > pas_pkg::HOUR_LAST) begin
                norm_inc_day = 1'b1;
            end else if (raw_minute_reg > pas_pkg::MIN_LAST) begin
                if (raw_hour_reg == pas_pkg::HOUR_LAST) begin
                    norm_inc_day = 1'b1;
                end else begin
                    norm_hour_next   = raw_hour_reg + 5'd1;
                    norm_minute_next = 6'd0;
                    norm_second_next = 6'd0;
                end
            end else if (raw_second_reg > pas_pkg::SEC_LAST) begin
                if (raw_minute_reg != pas_pkg::MIN_LAST) begin
                    norm_minute_next = raw_minute_reg + 6'd1;
                    norm_second_next = 6'd0;
                end else if (raw_hour_reg == pas_pkg::HOUR_LAST) begin
                    norm_inc_day = 1'b1;
                end else begin
                    norm_hour_next   = raw_hour_reg + 5'd1;
                    norm_minute_next = 6'd0;
                    norm_second_next = 6'd0;
                end
            end

            if (norm_inc_day) begin
                if (raw_day_reg == raw_ml) begin
                    norm_new_month = 1'b1;
                end else begin
                    norm_day_next    = raw_day_reg + 5'd1;
                    norm_hour_next   = 5'd0;
                    norm_minute_next = 6'd0;
                    norm_second_next = 6'd0;
                end
            end

            if (norm_new_month) begin
                if (raw_month_reg == pas_pkg::MONTHS_PER_YEAR) begin
                    norm_year_next  = {1'b0, raw_year_reg} + 9'd1;
                    norm_month_next = 4'd1;
                end else begin
                    norm_month_next = raw_month_reg + 4'd1;
                end
                norm_day_next    = 5'd1;
                norm_hour_next   = 5'd0;
                norm_minute_next = 6'd0;
                norm_second_next = 6'd0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Alarm plus one period. The period is under one day, so the day moves
    // by at most one.
    // ------------------------------------------------------------------
    assign alarm_ml = pas_pkg::month_len(alarm_year_reg, alarm_month_reg);

    always_comb begin
        sum_sec   = {1'b0, alarm_second_reg} + {1'b0, per_sec_reg};
        carry_sec = (sum_sec >= pas_pkg::SECS_PER_MIN);
        adv_second_next = carry_sec ? 6'(sum_sec - pas_pkg::SECS_PER_MIN) : sum_sec[5:0];

        sum_min   = {1'b0, alarm_minute_reg} + {1'b0, per_min_reg} + {6'd0, carry_sec};
        carry_min = (sum_min >= pas_pkg::MINS_PER_HOUR);
        adv_minute_next = carry_min ? 6'(sum_min - pas_pkg::MINS_PER_HOUR) : sum_min[5:0];

        sum_hour   = {1'b0, alarm_hour_reg} + {1'b0, per_hour_reg} + {5'd0, carry_min};
        carry_hour = (sum_hour >= pas_pkg::HOURS_PER_DAY);
        adv_hour_next = carry_hour ? 5'(sum_hour - pas_pkg::HOURS_PER_DAY) : sum_hour[4:0];

        adv_year_next  = alarm_year_reg;
        adv_month_next = alarm_month_reg;
        adv_day_next   = alarm_day_reg;
        adv_wrap_next  = 1'b0;
        if (carry_hour) begin
            if (alarm_day_reg == alarm_ml) begin
                adv_day_next = 5'd1;
                if (alarm_month_reg == pas_pkg::MONTHS_PER_YEAR) begin
                    adv_month_next = 4'd1;
                    {adv_wrap_next, adv_year_next} = {1'b0, alarm_year_reg} + 9'd1;
                end else begin
                    adv_month_next = alarm_month_reg + 4'd1;
                end
            end else begin
                adv_day_next = alarm_day_reg + 5'd1;
            end
        end
    end

    assign alarm_lt_now = {1'b0, alarm_year_reg, alarm_month_reg, alarm_day_reg,
                           alarm_hour_reg, alarm_minute_reg, alarm_second_reg}
                        < {now_year_reg, now_month_reg, now_day_reg,
                           now_hour_reg, now_minute_reg, now_second_reg};

    assign stat.op           = op_reg;
    assign stat.period_ok    = (period_status == pas_pkg::STATUS_OK);
    assign stat.alarm_lt_now = alarm_lt_now;
    assign stat.adv          = alarm_lt_now && !wrap_reg;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            per_sec_reg  <= 6'd0;
            per_min_reg  <= 6'd0;
            per_hour_reg <= 5'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pas_pkg::CFG_PERIOD_SECONDS: per_sec_reg  <= cfg_data;
                pas_pkg::CFG_PERIOD_MINUTES: per_min_reg  <= cfg_data;
                pas_pkg::CFG_PERIOD_HOURS:   per_hour_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request and normalized time registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg         <= s_op;
            raw_year_reg   <= s_now_year;
            raw_month_reg  <= s_now_month;
            raw_day_reg    <= s_now_day;
            raw_hour_reg   <= s_now_hour;
            raw_minute_reg <= s_now_minute;
            raw_second_reg <= s_now_second;
        end
        if (cmd.normalize) begin
            now_year_reg   <= norm_year_next;
            now_month_reg  <= norm_month_next;
            now_day_reg    <= norm_day_next;
            now_hour_reg   <= norm_hour_next;
            now_minute_reg <= norm_minute_next;
            now_second_reg <= norm_second_next;
        end
    end

    // ------------------------------------------------------------------
    // Alarm, skip count and wake tracking
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_year_reg   <= 8'd0;
            alarm_month_reg  <= 4'd1;
            alarm_day_reg    <= 5'd1;
            alarm_hour_reg   <= 5'd0;
            alarm_minute_reg <= 6'd0;
            alarm_second_reg <= 6'd0;
            skip_reg         <= '0;
            wake_pending_reg <= 1'b1;
            first_reg        <= 1'b0;
            wrap_reg         <= 1'b0;
        end else begin
            if (cmd.capture) begin
                wake_pending_reg <= wake_pending_reg | s_timer_fired;
            end

            if (cmd.eval) begin
                wrap_reg <= 1'b0;
                if (op_reg == pas_pkg::OP_START) begin
                    skip_reg <= '0;
                    // A time at the end of the calendar loads as year 0.
                    if (period_status == pas_pkg::STATUS_OK) begin
                        alarm_year_reg   <= now_year_reg[7:0];
                        alarm_month_reg  <= now_month_reg;
                        alarm_day_reg    <= now_day_reg;
                        alarm_hour_reg   <= now_hour_reg;
                        alarm_minute_reg <= now_minute_reg;
                        alarm_second_reg <= now_second_reg;
                    end
                end else if (period_status == pas_pkg::STATUS_OK && alarm_lt_now) begin
                    // The first advance after a wake is the expected one.
                    if (wake_pending_reg) begin
                        wake_pending_reg <= 1'b0;
                        skip_reg         <= '0;
                        first_reg        <= 1'b1;
                    end else begin
                        first_reg <= 1'b0;
                    end
                end
            end

            if (cmd.step) begin
                alarm_year_reg   <= adv_year_next;
                alarm_month_reg  <= adv_month_next;
                alarm_day_reg    <= adv_day_next;
                alarm_hour_reg   <= adv_hour_next;
                alarm_minute_reg <= adv_minute_next;
                alarm_second_reg <= adv_second_next;
                wrap_reg         <= adv_wrap_next;
                if (first_reg) begin
                    first_reg <= 1'b0;
                end else if (skip_reg != pas_pkg::SKIP_MAX) begin
                    skip_reg <= skip_reg + 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status         <= period_status;
            m_match_mode     <= period_mode;
            m_alarm_year     <= alarm_year_reg;
            m_alarm_month    <= alarm_month_reg;
            m_alarm_day      <= alarm_day_reg;
            m_alarm_hour     <= alarm_hour_reg;
            m_alarm_minute   <= alarm_minute_reg;
            m_alarm_second   <= alarm_second_reg;
            m_skipped_cycles <= skip_reg;
        end
    end

    a_alarm_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (alarm_month_reg >= 4'd1) && (alarm_month_reg <= pas_pkg::MONTHS_PER_YEAR) &&
        (alarm_day_reg >= 5'd1) && (alarm_day_reg <= alarm_ml) &&
        (alarm_hour_reg <= pas_pkg::HOUR_LAST) && (alarm_minute_reg <= pas_pkg::MIN_LAST) &&
        (alarm_second_reg <= pas_pkg::SEC_LAST))
        else $error("alarm register holds an invalid calendar time");

    a_first_clears_wake: assert property (@(posedge aclk) disable iff (!aresetn)
        first_reg |-> !wake_pending_reg)
        else $error("uncounted advance pending while wake is still set");

    a_wrap_at_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        wrap_reg |-> (alarm_year_reg == 8'd0 && alarm_month_reg == 4'd1 &&
                      alarm_day_reg == 5'd1))
        else $error("year wrap flagged away from the start of the calendar");

endmodule

// ===== rtl/core/periodic_alarm_scheduler_top.sv =====
`timescale 1ns / 1ps
// A start request, or a schedule request that needs no catch-up, passes through the
// normalize, eval and done states; no new request is taken before its result loads.
// A schedule request that advances the alarm k periods also passes through the
// catch-up state, where the calendar adder moves the alarm by one period per cycle.
// Reset (aresetn, synchronous, active low) clears the period to zero, the alarm to
// year 0 January 1 00:00:00, the skip count to zero, and marks a wake as pending.
// ----------------------------------------------------------------------------
// Periodic alarm scheduler
// Keeps a calendar alarm and moves it forward by a configured period until
// it is no longer before the current time, counting skipped periods.
// ----------------------------------------------------------------------------
module periodic_alarm_scheduler_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [5:0]                 cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  logic [7:0]                 s_now_year,
    input  logic [3:0]                 s_now_month,
    input  logic [4:0]                 s_now_day,
    input  logic [4:0]                 s_now_hour,
    input  logic [5:0]                 s_now_minute,
    input  logic [5:0]                 s_now_second,
    input  logic                       s_timer_fired,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic [1:0]                 m_match_mode,
    output logic [7:0]                 m_alarm_year,
    output logic [3:0]                 m_alarm_month,
    output logic [4:0]                 m_alarm_day,
    output logic [4:0]                 m_alarm_hour,
    output logic [5:0]                 m_alarm_minute,
    output logic [5:0]                 m_alarm_second,
    output logic [pas_pkg::SKIP_W-1:0] m_skipped_cycles
);

    pas_pkg::pas_cmd_t  cmd;
    pas_pkg::pas_stat_t stat;
    logic               cfg_we;

    // Period registers are to be written only while idle; the block does not enforce it, so writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    pas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pas_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_op             (s_op),
        .s_now_year       (s_now_year),
        .s_now_month      (s_now_month),
        .s_now_day        (s_now_day),
        .s_now_hour       (s_now_hour),
        .s_now_minute     (s_now_minute),
        .s_now_second     (s_now_second),
        .s_timer_fired    (s_timer_fired),
        .cmd              (cmd),
        .stat             (stat),
        .m_status         (m_status),
        .m_match_mode     (m_match_mode),
        .m_alarm_year     (m_alarm_year),
        .m_alarm_month    (m_alarm_month),
        .m_alarm_day      (m_alarm_day),
        .m_alarm_hour     (m_alarm_hour),
        .m_alarm_minute   (m_alarm_minute),
        .m_alarm_second   (m_alarm_second),
        .m_skipped_cycles (m_skipped_cycles)
    );

endmodule
